FILE: rtl/kdeq_pkg.sv
// Shared types and constants for the key debounce event queue.
// No dependencies; every other file in rtl/ imports this package.
package kdeq_pkg;

	localparam int KEY_W  = 2;   // key index carried in events and commands
	localparam int RAW_W  = 4;   // width of the raw level and read status words
	localparam int TICK_W = 4;   // debounce counters and tick registers
	localparam int ADDR_W = 3;   // APB byte address
	localparam int DATA_W = 32;  // APB data
	localparam int REG_SEL_BIT = 2;

	localparam logic [TICK_W-1:0] DEFAULT_TICKS = TICK_W'(4);

	// register select, taken from paddr[REG_SEL_BIT]
	localparam logic REG_PRESS   = 1'b0;
	localparam logic REG_RELEASE = 1'b1;

	typedef enum logic [2:0] {
		CMD_SCAN    = 3'd0,
		CMD_EDGE    = 3'd1,
		CMD_POP     = 3'd2,
		CMD_CONSUME = 3'd3,
		CMD_INIT    = 3'd4
	} cmd_t;

	typedef struct packed {
		logic              stable;
		logic              armed;
		logic [TICK_W-1:0] press_cnt;
		logic [TICK_W-1:0] rel_cnt;
	} key_state_t;

	// request from the sequencer to the event queue
	typedef struct packed {
		logic             push;
		logic             pop;
		logic             consume;
		logic             clear;
		logic [KEY_W-1:0] key;
	} q_req_t;

	// completion of a pop or consume request
	typedef struct packed {
		logic             done;
		logic             ok;
		logic [KEY_W-1:0] key;
	} q_stat_t;

endpackage

FILE: rtl/kdeq_debounce.sv
// Per-key debounce update: one key's counters and flags against one sample.
// Depends on kdeq_pkg (key_state_t, TICK_W).
module kdeq_debounce import kdeq_pkg::*; (
	input  key_state_t        state_in,
	input  logic              sample,
	input  logic              sample_ok,
	input  logic [TICK_W-1:0] press_ticks,
	input  logic [TICK_W-1:0] release_ticks,
	output key_state_t        state_out,
	output logic              confirm
);

	always_comb begin
		logic [TICK_W-1:0] cnt;
		cnt = '0;
		state_out = state_in;
		confirm = 1'b0;
		if ((state_in.armed || state_in.stable) && sample_ok) begin
			if (!state_in.stable) begin
				if (sample) begin
					cnt = (state_in.press_cnt < press_ticks) ?
						state_in.press_cnt + 1'b1 : state_in.press_cnt;
					if (cnt >= press_ticks) begin
						confirm = 1'b1;
						state_out = '{stable: 1'b1, armed: 1'b0, press_cnt: '0, rel_cnt: '0};
					end else begin
						state_out.press_cnt = cnt;
					end
				end else begin
					// contrary sample: drop the attempt
					state_out.press_cnt = '0;
					state_out.armed = 1'b0;
				end
			end else begin
				if (!sample) begin
					cnt = (state_in.rel_cnt < release_ticks) ?
						state_in.rel_cnt + 1'b1 : state_in.rel_cnt;
					if (cnt >= release_ticks) begin
						state_out = '{stable: 1'b0, armed: 1'b0, press_cnt: '0, rel_cnt: '0};
					end else begin
						state_out.rel_cnt = cnt;
					end
				end else begin
					state_out.rel_cnt = '0;
					state_out.armed = 1'b0;
				end
			end
		end
	end

endmodule

FILE: rtl/kdeq_queue.sv
// Event FIFO: single-port-read store with head and fill, pop and keyed removal.
// Depends on kdeq_pkg (q_req_t, q_stat_t, KEY_W).
module kdeq_queue import kdeq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	localparam int AW = $clog2(QUEUE_DEPTH),
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  q_req_t        req,
	output q_stat_t       stat,
	output logic [CW-1:0] fill
);

	typedef enum logic [1:0] {Q_IDLE, Q_POP, Q_SRCH, Q_SHIFT} q_state_t;

	q_state_t         state_q;
	logic [AW-1:0]    head_q;
	logic [CW-1:0]    fill_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    idx_s1;
	logic             v_s1;
	logic [KEY_W-1:0] key_q;
	q_stat_t          stat_q;
	q_stat_t          stat_d;

	logic [KEY_W-1:0] mem [QUEUE_DEPTH];
	logic [KEY_W-1:0] rd_data_q;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;
	logic [KEY_W-1:0] wr_data;
	logic             wr_en;

	// ring position of the entry at offset k from the head
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] head, input logic [CW-1:0] k);
		logic [CW:0] s;
		s = (CW+1)'(head) + (CW+1)'(k);
		if (s >= (CW+1)'(QUEUE_DEPTH))
			s = s - (CW+1)'(QUEUE_DEPTH);
		return s[AW-1:0];
	endfunction

	always_comb begin
		rd_addr = head_q;
		wr_en   = 1'b0;
		wr_addr = slot(head_q, fill_q);
		wr_data = req.key;
		stat_d  = '0;
		unique case (state_q)
			Q_IDLE: begin
				wr_en = req.push && !req.clear && (fill_q != CW'(QUEUE_DEPTH));
				if (!req.clear && !req.push && (req.pop || req.consume) && (fill_q == '0))
					stat_d = '{done: 1'b1, ok: 1'b0, key: '0};
			end
			Q_POP: begin
				stat_d = '{done: 1'b1, ok: 1'b1, key: rd_data_q};
			end
			Q_SRCH: begin
				rd_addr = slot(head_q, idx_q);
				if (!(v_s1 && (rd_data_q == key_q)) && !(idx_q < fill_q))
					stat_d = '{done: 1'b1, ok: 1'b0, key: '0};
			end
			Q_SHIFT: begin
				// move the entry read last cycle one place toward the head
				rd_addr = slot(head_q, idx_q);
				wr_en   = v_s1;
				wr_addr = slot(head_q, CW'(idx_s1 - 1'b1));
				wr_data = rd_data_q;
				if (!(idx_q < fill_q) && !v_s1)
					stat_d = '{done: 1'b1, ok: 1'b1, key: '0};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= Q_IDLE;
			head_q  <= '0;
			fill_q  <= '0;
			v_s1    <= 1'b0;
			stat_q  <= '0;
		end else begin
			stat_q <= stat_d;
			unique case (state_q)
				Q_IDLE: begin
					if (req.clear) begin
						head_q <= '0;
						fill_q <= '0;
					end else if (req.push) begin
						if (fill_q != CW'(QUEUE_DEPTH))
							fill_q <= fill_q + 1'b1;
					end else if (req.pop) begin
						if (fill_q != '0)
							state_q <= Q_POP;
					end else if (req.consume) begin
						if (fill_q != '0) begin
							key_q   <= req.key;
							idx_q   <= '0;
							v_s1    <= 1'b0;
							state_q <= Q_SRCH;
						end
					end
				end
				Q_POP: begin
					head_q  <= slot(head_q, CW'(1));
					fill_q  <= fill_q - 1'b1;
					state_q <= Q_IDLE;
				end
				Q_SRCH: begin
					if (v_s1 && (rd_data_q == key_q)) begin
						// hit: restart the read stream just past it
						idx_q   <= idx_s1 + 1'b1;
						v_s1    <= 1'b0;
						state_q <= Q_SHIFT;
					end else if (idx_q < fill_q) begin
						v_s1   <= 1'b1;
						idx_s1 <= idx_q;
						idx_q  <= idx_q + 1'b1;
					end else begin
						v_s1    <= 1'b0;
						state_q <= Q_IDLE;
					end
				end
				Q_SHIFT: begin
					if (idx_q < fill_q) begin
						v_s1   <= 1'b1;
						idx_s1 <= idx_q;
						idx_q  <= idx_q + 1'b1;
					end else begin
						v_s1 <= 1'b0;
						if (!v_s1) begin
							fill_q  <= fill_q - 1'b1;
							state_q <= Q_IDLE;
						end
					end
				end
				default: state_q <= Q_IDLE;
			endcase
		end
	end

	assign stat = stat_q;
	assign fill = fill_q;

endmodule

FILE: rtl/key_debounce_event_queue_core.sv
// Top level of the key debouncer with press event FIFO: command sequencer,
// per-key state, tick registers behind an APB port, and the result register.
// Depends on kdeq_pkg, kdeq_debounce and kdeq_queue.
//
// One request is in work at a time; in_ready is high only while the sequencer
// is idle. A scan tick walks the keys one per cycle through a single debounce
// update unit; a consume searches and then compacts the event store one entry
// per cycle through its one read port. A finished result waits in the output
// register until taken. The tick registers reset to 4 and are written at byte
// addresses 0 (press) and 4 (release); a value of 0 behaves like 1. The event
// store has no reset and needs no clearing pass.
module key_debounce_event_queue_core import kdeq_pkg::*; #(
	parameter int NUM_KEYS    = 4,
	parameter int QUEUE_DEPTH = 16,
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        cmd,
	input  logic [KEY_W-1:0]  key_index,
	input  logic [RAW_W-1:0]  key_down,
	input  logic [RAW_W-1:0]  read_ok,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              ok,
	output logic [KEY_W-1:0]  key_out,
	output logic [RAW_W-1:0]  pressed_mask,
	output logic [CNT_W-1:0]  queue_count,
	output logic              dropped,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int KEY_IW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_QWAIT, ST_FIN} state_t;

	state_t             state_q;
	logic [KEY_IW-1:0]  sc_q;
	logic [NUM_KEYS-1:0] raw_q;
	logic [NUM_KEYS-1:0] rok_q;
	logic               res_ok_q;
	logic [KEY_W-1:0]   res_key_q;
	logic               res_drop_q;
	logic               out_valid_q;
	logic               ok_q;
	logic [KEY_W-1:0]   key_out_q;
	logic [RAW_W-1:0]   mask_q;
	logic [CNT_W-1:0]   count_q;
	logic               drop_q;
	logic [TICK_W-1:0]  press_ticks_q;
	logic [TICK_W-1:0]  release_ticks_q;

	key_state_t         ks_q [NUM_KEYS];
	key_state_t         ks_cur;
	key_state_t         ks_next;
	logic               confirm;

	logic [NUM_KEYS-1:0] raw_in_ext;
	logic [NUM_KEYS-1:0] rok_in_ext;
	logic [RAW_W-1:0]   mask;
	logic               in_fire;
	logic               key_in_range;
	logic [KEY_IW-1:0]  key_sel;
	logic               full;
	logic               cfg_we;

	q_req_t             q_req;
	q_stat_t            q_stat;
	logic [CNT_W-1:0]   q_fill;

	// keys past the raw word have no pin: read failed, released
	for (genvar g = 0; g < NUM_KEYS; g++) begin : g_ext
		if (g < RAW_W) begin : g_pin
			assign raw_in_ext[g] = key_down[g];
			assign rok_in_ext[g] = read_ok[g];
		end else begin : g_nopin
			assign raw_in_ext[g] = 1'b0;
			assign rok_in_ext[g] = 1'b0;
		end
	end

	for (genvar g = 0; g < RAW_W; g++) begin : g_mask
		if (g < NUM_KEYS) begin : g_key
			assign mask[g] = ks_q[g].stable;
		end else begin : g_nokey
			assign mask[g] = 1'b0;
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign in_fire      = in_valid && in_ready;
	assign key_in_range = (int'(key_index) < NUM_KEYS);
	assign key_sel      = KEY_IW'(key_index);
	assign full         = (q_fill == CNT_W'(QUEUE_DEPTH));

	// configuration
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_ticks_q   <= DEFAULT_TICKS;
			release_ticks_q <= DEFAULT_TICKS;
		end else if (cfg_we) begin
			unique case (paddr[REG_SEL_BIT])
				REG_PRESS:   press_ticks_q   <= pwdata[TICK_W-1:0];
				REG_RELEASE: release_ticks_q <= pwdata[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[REG_SEL_BIT])
			REG_PRESS:   prdata = {{(DATA_W-TICK_W){1'b0}}, press_ticks_q};
			REG_RELEASE: prdata = {{(DATA_W-TICK_W){1'b0}}, release_ticks_q};
			default:     prdata = '0;
		endcase
	end

	// shared debounce unit, walked over the keys during a scan
	assign ks_cur = ks_q[sc_q];

	kdeq_debounce u_debounce (
		.state_in      (ks_cur),
		.sample        (raw_q[sc_q]),
		.sample_ok     (rok_q[sc_q]),
		.press_ticks   (press_ticks_q),
		.release_ticks (release_ticks_q),
		.state_out     (ks_next),
		.confirm       (confirm)
	);

	always_comb begin
		q_req.push    = (state_q == ST_SCAN) && confirm && !full;
		q_req.pop     = in_fire && (cmd == CMD_POP);
		q_req.consume = in_fire && (cmd == CMD_CONSUME) && key_in_range;
		q_req.clear   = in_fire && (cmd == CMD_INIT);
		q_req.key     = (state_q == ST_SCAN) ? KEY_W'(sc_q) : key_index;
	end

	kdeq_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (q_req),
		.stat   (q_stat),
		.fill   (q_fill)
	);

	// per-key state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_KEYS; i++)
				ks_q[i] <= '0;
		end else if (in_fire && (cmd == CMD_EDGE)) begin
			if (key_in_range && !ks_q[key_sel].stable) begin
				ks_q[key_sel].armed     <= 1'b1;
				ks_q[key_sel].press_cnt <= '0;
			end
		end else if (in_fire && (cmd == CMD_INIT)) begin
			for (int i = 0; i < NUM_KEYS; i++)
				ks_q[i] <= '{stable: raw_in_ext[i] && rok_in_ext[i], armed: 1'b0,
					press_cnt: '0, rel_cnt: '0};
		end else if (state_q == ST_SCAN) begin
			ks_q[sc_q] <= ks_next;
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			sc_q        <= '0;
		end else begin
			// ST_FIN reloads the result register on its own
			if (out_valid_q && out_ready && (state_q != ST_FIN))
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						res_ok_q   <= 1'b0;
						res_key_q  <= '0;
						res_drop_q <= 1'b0;
						raw_q      <= raw_in_ext;
						rok_q      <= rok_in_ext;
						sc_q       <= '0;
						unique case (cmd)
							CMD_SCAN:    state_q <= ST_SCAN;
							CMD_POP:     state_q <= ST_QWAIT;
							CMD_CONSUME: state_q <= key_in_range ? ST_QWAIT : ST_FIN;
							default:     state_q <= ST_FIN;
						endcase
					end
				end
				ST_SCAN: begin
					if (confirm && full)
						res_drop_q <= 1'b1;
					if (sc_q == KEY_IW'(NUM_KEYS - 1))
						state_q <= ST_FIN;
					else
						sc_q <= sc_q + 1'b1;
				end
				ST_QWAIT: begin
					if (q_stat.done) begin
						res_ok_q  <= q_stat.ok;
						res_key_q <= q_stat.key;
						state_q   <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold until the previous result is taken
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						ok_q        <= res_ok_q;
						key_out_q   <= res_key_q;
						drop_q      <= res_drop_q;
						mask_q      <= mask;
						count_q     <= q_fill;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign ok           = ok_q;
	assign key_out      = key_out_q;
	assign pressed_mask = mask_q;
	assign queue_count  = count_q;
	assign dropped      = drop_q;

endmodule

FILE: rtl/kdeq_checker.sv
// Port-level checks for the key debounce event queue, bound to the top level.
// Depends on kdeq_pkg (KEY_W) and key_debounce_event_queue_core.
module kdeq_checker import kdeq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic             ok,
	input logic [KEY_W-1:0] key_out,
	input logic [CNT_W-1:0] queue_count,
	input logic             dropped
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(key_out) && $stable(queue_count))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in work");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped |-> queue_count == CNT_W'(QUEUE_DEPTH))
		else $error("event dropped but queue not full");

	a_ok_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ok |-> queue_count < CNT_W'(QUEUE_DEPTH))
		else $error("event removed but queue still full");

endmodule

bind key_debounce_event_queue_core kdeq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_kdeq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.ok          (ok),
	.key_out     (key_out),
	.queue_count (queue_count),
	.dropped     (dropped)
);

FILE: tb/sv/tb_key_debounce_event_queue_core.sv
// Self-checking testbench for key_debounce_event_queue_core: random and directed
// key requests through the valid/ready ports, tick settings over APB, and
// checks every report against a cycle-free model. Depends on kdeq_pkg.
module tb_key_debounce_event_queue_core;
	import kdeq_pkg::*;

	localparam int NKEYS        = 4;
	localparam int QDEPTH       = 16;
	localparam int CNT_W        = $clog2(QDEPTH + 1);
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_REQS  = 1450;
	localparam int SEGMENTS     = 8;
	localparam int SETTLE       = 60;
	localparam int MAX_PRINTS   = 40;
	localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
	// tick settings per segment, segment 0 in the low nibble
	localparam logic [SEGMENTS*TICK_W-1:0] PRESS_SETTINGS   = 32'h4315_2F01;
	localparam logic [SEGMENTS*TICK_W-1:0] RELEASE_SETTINGS = 32'h42F1_3F01;

	typedef enum logic [2:0] {ST_REQ, ST_CFG, ST_DRAIN, ST_PACE, ST_HOLD} stim_kind_t;

	typedef struct packed {
		stim_kind_t        kind;
		logic [2:0]        op;
		logic [KEY_W-1:0]  key;
		logic [RAW_W-1:0]  raw;
		logic [RAW_W-1:0]  rok;
		logic              reg_sel;
		logic [TICK_W-1:0] ticks;
		logic [6:0]        idle_pct;
		logic [6:0]        stall_pct;
	} stim_t;

	typedef struct packed {
		logic              ok;
		logic [KEY_W-1:0]  key_out;
		logic [RAW_W-1:0]  pressed_mask;
		logic [CNT_W-1:0]  queue_count;
		logic              dropped;
	} report_t;

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic [2:0]        cmd         = CMD_SCAN;
	logic [KEY_W-1:0]  key_index   = '0;
	logic [RAW_W-1:0]  key_down    = '0;
	logic [RAW_W-1:0]  read_ok     = '0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic              ok;
	logic [KEY_W-1:0]  key_out;
	logic [RAW_W-1:0]  pressed_mask;
	logic [CNT_W-1:0]  queue_count;
	logic              dropped;
	logic              psel        = 1'b0;
	logic              penable     = 1'b0;
	logic              pwrite      = 1'b0;
	logic [ADDR_W-1:0] paddr       = '0;
	logic [DATA_W-1:0] pwdata      = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	key_debounce_event_queue_core #(.NUM_KEYS(NKEYS), .QUEUE_DEPTH(QDEPTH)) u_dut (.*);

	// model state
	logic              key_stable  [NKEYS];
	logic              key_armed   [NKEYS];
	logic [TICK_W-1:0] press_run   [NKEYS];
	logic [TICK_W-1:0] release_run [NKEYS];
	logic [KEY_W-1:0]  fifo_key    [QDEPTH];
	int                fifo_head, fifo_fill;
	logic [TICK_W-1:0] press_need, release_need;

	stim_t   stim_q[$];
	report_t predicted_reports[$];

	int       planned_reqs, requests_sent, reports_taken;
	int       errors, cfg_writes, drops_predicted;
	int       hold_requests, holds_served, hold_left;
	int       plan_press, plan_release;
	int       cfg_phase;
	logic [6:0] idle_pct  = '0;
	logic [6:0] stall_pct = '0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic report_t predict_key_report(logic [2:0] op, logic [KEY_W-1:0] key,
			logic [RAW_W-1:0] raw, logic [RAW_W-1:0] rok);
		report_t r;
		int k, hit;
		r = '0;
		case (op)
		CMD_SCAN: begin
			for (k = 0; k < NKEYS; k++) begin
				if ((key_armed[k] || key_stable[k]) && rok[k]) begin
					if (!key_stable[k] && raw[k]) begin
						if (press_run[k] < press_need) press_run[k]++;
						if (press_run[k] >= press_need) begin
							key_stable[k] = 1'b1;
							if (fifo_fill < QDEPTH) begin
								fifo_key[(fifo_head + fifo_fill) % QDEPTH] = KEY_W'(k);
								fifo_fill++;
							end else begin
								r.dropped = 1'b1;
								drops_predicted++;
							end
							press_run[k]   = '0;
							release_run[k] = '0;
							key_armed[k]   = 1'b0;
						end
					end else if (!key_stable[k]) begin
						press_run[k] = '0;
						key_armed[k] = 1'b0;
					end else if (!raw[k]) begin
						if (release_run[k] < release_need) release_run[k]++;
						if (release_run[k] >= release_need) begin
							key_stable[k]  = 1'b0;
							release_run[k] = '0;
							press_run[k]   = '0;
							key_armed[k]   = 1'b0;
						end
					end else begin
						release_run[k] = '0;
						key_armed[k]   = 1'b0;
					end
				end
			end
		end
		CMD_EDGE: begin
			if (!key_stable[key]) begin
				key_armed[key] = 1'b1;
				press_run[key] = '0;
			end
		end
		CMD_POP: begin
			if (fifo_fill > 0) begin
				r.ok      = 1'b1;
				r.key_out = fifo_key[fifo_head];
				fifo_head = (fifo_head + 1) % QDEPTH;
				fifo_fill--;
			end
		end
		CMD_CONSUME: begin
			hit = -1;
			for (k = 0; k < fifo_fill && hit < 0; k++)
				if (fifo_key[(fifo_head + k) % QDEPTH] == key) hit = k;
			if (hit >= 0) begin
				// close the gap: later entries move one place toward the head
				for (k = hit; k + 1 < fifo_fill; k++)
					fifo_key[(fifo_head + k) % QDEPTH] = fifo_key[(fifo_head + k + 1) % QDEPTH];
				fifo_fill--;
				r.ok = 1'b1;
			end
		end
		CMD_INIT: begin
			fifo_head = 0;
			fifo_fill = 0;
			for (k = 0; k < NKEYS; k++) begin
				key_stable[k]  = rok[k] && raw[k];
				press_run[k]   = '0;
				release_run[k] = '0;
				key_armed[k]   = 1'b0;
			end
		end
		default: begin
		end
		endcase
		for (k = 0; k < NKEYS; k++) r.pressed_mask[k] = key_stable[k];
		r.queue_count = CNT_W'(fifo_fill);
		return r;
	endfunction

	task automatic flag_mismatch(string field, int got, int want);
		if (errors < MAX_PRINTS)
			$display("mismatch at report %0d: %s got %0d, want %0d", reports_taken, field, got, want);
		errors++;
	endtask

	// stimulus builders
	task automatic add_req(logic [2:0] op, logic [KEY_W-1:0] key, logic [RAW_W-1:0] raw,
			logic [RAW_W-1:0] rok);
		stim_t s;
		s = '0;
		s.kind = ST_REQ;
		s.op   = op;
		s.key  = key;
		s.raw  = raw;
		s.rok  = rok;
		stim_q.push_back(s);
		if (op <= CMD_INIT) planned_reqs++;
	endtask

	task automatic add_cfg(logic reg_sel, logic [TICK_W-1:0] ticks);
		stim_t s;
		s = '0;
		s.kind    = ST_CFG;
		s.reg_sel = reg_sel;
		s.ticks   = ticks;
		stim_q.push_back(s);
	endtask

	task automatic add_pace(int idle, int stall);
		stim_t s;
		s = '0;
		s.kind      = ST_PACE;
		s.idle_pct  = 7'(idle);
		s.stall_pct = 7'(stall);
		stim_q.push_back(s);
	endtask

	task automatic add_ctl(stim_kind_t kind);
		stim_t s;
		s = '0;
		s.kind = kind;
		stim_q.push_back(s);
	endtask

	function automatic int ticks_needed(int t);
		return (t == 0) ? 1 : t;
	endfunction

	function automatic logic [RAW_W-1:0] scan_rok();
		logic [RAW_W-1:0] rok;
		rok = '1;
		if ($urandom_range(7) == 0) rok[$urandom_range(NKEYS - 1)] = 1'b0;
		return rok;
	endfunction

	// arm a set of keys, hold them long enough to confirm, then usually let go
	task automatic press_release(logic [RAW_W-1:0] keys);
		int first, n, j;
		logic [RAW_W-1:0] raw;
		first = $urandom_range(NKEYS - 1);
		for (j = 0; j < NKEYS; j++)
			if (keys[(first + j) % NKEYS])
				add_req(CMD_EDGE, KEY_W'((first + j) % NKEYS), RAW_W'($urandom), RAW_W'($urandom));
		n = ticks_needed(plan_press) + $urandom_range(1, 0);
		for (j = 0; j < n; j++) begin
			raw = keys | RAW_W'($urandom);
			if ($urandom_range(9) == 0) raw ^= keys & RAW_W'($urandom);
			add_req(CMD_SCAN, KEY_W'($urandom), raw, scan_rok());
		end
		if ($urandom_range(4) != 0) begin
			n = ticks_needed(plan_release) + $urandom_range(1, 0);
			for (j = 0; j < n; j++) begin
				raw = RAW_W'($urandom) & ~keys;
				if ($urandom_range(9) == 0) raw |= keys & RAW_W'($urandom);
				add_req(CMD_SCAN, KEY_W'($urandom), raw, scan_rok());
			end
		end
	endtask

	// sender: one request in flight on the input, APB writes only while idle
	always @(posedge clk or negedge arst_n) begin
		stim_t nxt;
		logic launch;
		if (!arst_n) begin
			in_valid      <= 1'b0;
			cmd           <= CMD_SCAN;
			key_index     <= '0;
			key_down      <= '0;
			read_ok       <= '0;
			psel          <= 1'b0;
			penable       <= 1'b0;
			pwrite        <= 1'b0;
			paddr         <= '0;
			pwdata        <= '0;
			cfg_phase     <= 0;
			requests_sent <= 0;
			hold_requests <= 0;
		end else begin
			launch = 1'b0;
			if (in_valid && in_ready) begin
				predicted_reports.push_back(predict_key_report(cmd, key_index, key_down, read_ok));
				requests_sent <= requests_sent + 1;
			end
			if (cfg_phase == 1) begin
				penable   <= 1'b1;
				cfg_phase <= 2;
			end else if (cfg_phase == 2) begin
				if (pready) begin
					if (paddr[REG_SEL_BIT] == REG_RELEASE) release_need = pwdata[TICK_W-1:0];
					else press_need = pwdata[TICK_W-1:0];
					cfg_writes++;
					psel      <= 1'b0;
					penable   <= 1'b0;
					pwrite    <= 1'b0;
					cfg_phase <= 0;
				end
			end else if (!(in_valid && !in_ready) && stim_q.size() > 0) begin
				nxt = stim_q[0];
				case (nxt.kind)
				ST_REQ: begin
					if ($urandom_range(99) >= idle_pct) begin
						void'(stim_q.pop_front());
						cmd         <= nxt.op;
						key_index   <= nxt.key;
						key_down    <= nxt.raw;
						read_ok     <= nxt.rok;
						launch = 1'b1;
					end
				end
				ST_CFG: begin
					if (!in_valid && requests_sent == reports_taken) begin
						void'(stim_q.pop_front());
						psel      <= 1'b1;
						pwrite    <= 1'b1;
						paddr     <= ADDR_W'(nxt.reg_sel) << REG_SEL_BIT;
						pwdata    <= DATA_W'(nxt.ticks);
						cfg_phase <= 1;
					end
				end
				ST_DRAIN: begin
					// hold off until every report is back
					if (!in_valid && requests_sent == reports_taken) void'(stim_q.pop_front());
				end
				ST_PACE: begin
					void'(stim_q.pop_front());
					idle_pct  <= nxt.idle_pct;
					stall_pct <= nxt.stall_pct;
				end
				default: begin
					void'(stim_q.pop_front());
					hold_requests <= hold_requests + 1;
				end
				endcase
			end
			if (!(in_valid && !in_ready)) in_valid <= launch;
		end
	end

	// long receiver hold-off, counted here so the monitor only sees a flag
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left    <= 0;
			holds_served <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_served != hold_requests) begin
			holds_served <= holds_served + 1;
			hold_left    <= HOLD_CYCLES;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		report_t want;
		if (!arst_n) begin
			out_ready     <= 1'b0;
			reports_taken <= 0;
		end else begin
			if (out_valid && out_ready) begin
				reports_taken <= reports_taken + 1;
				if (predicted_reports.size() == 0) begin
					flag_mismatch("unexpected report, queue_count", queue_count, 0);
				end else begin
					want = predicted_reports.pop_front();
					if (ok !== want.ok) flag_mismatch("ok", ok, want.ok);
					if (key_out !== want.key_out) flag_mismatch("key_out", key_out, want.key_out);
					if (pressed_mask !== want.pressed_mask)
						flag_mismatch("pressed_mask", pressed_mask, want.pressed_mask);
					if (queue_count !== want.queue_count)
						flag_mismatch("queue_count", queue_count, want.queue_count);
					if (dropped !== want.dropped) flag_mismatch("dropped", dropped, want.dropped);
				end
			end
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		int k, seg, pick, goal;
		for (k = 0; k < NKEYS; k++) begin
			key_stable[k]  = 1'b0;
			key_armed[k]   = 1'b0;
			press_run[k]   = '0;
			release_run[k] = '0;
		end
		fifo_head       = 0;
		fifo_fill       = 0;
		press_need      = DEFAULT_TICKS;
		release_need    = DEFAULT_TICKS;
		plan_press      = DEFAULT_TICKS;
		plan_release    = DEFAULT_TICKS;
		errors          = 0;
		cfg_writes      = 0;
		drops_predicted = 0;
		planned_reqs    = 0;

		// directed: empty queue, unknown commands, init with failed reads,
		// edge on a held key, failed read during a scan, consume and pops
		add_req(CMD_POP, '0, '0, '0);
		add_req(CMD_CONSUME, KEY_W'(3), '1, '1);
		for (k = CMD_FIRST_UNUSED; k < 8; k++)
			add_req(3'(k), KEY_W'($urandom), RAW_W'($urandom), RAW_W'($urandom));
		add_req(CMD_INIT, '0, 4'b1111, 4'b0101);
		add_req(CMD_EDGE, KEY_W'(0), '0, '1);
		add_req(CMD_EDGE, KEY_W'(1), '0, '1);
		add_req(CMD_EDGE, KEY_W'(3), '0, '1);
		add_req(CMD_SCAN, '0, 4'b1010, 4'b0111);
		repeat (4) add_req(CMD_SCAN, '0, 4'b1010, 4'b1111);
		add_req(CMD_SCAN, '0, 4'b0010, 4'b1111);
		add_req(CMD_CONSUME, KEY_W'(3), '0, '0);
		add_req(CMD_CONSUME, KEY_W'(2), '0, '0);
		add_req(CMD_POP, '0, '0, '0);
		add_req(CMD_POP, '0, '0, '0);
		add_ctl(ST_DRAIN);

		for (seg = 0; seg < SEGMENTS; seg++) begin
			plan_press   = PRESS_SETTINGS[seg*TICK_W +: TICK_W];
			plan_release = RELEASE_SETTINGS[seg*TICK_W +: TICK_W];
			add_cfg(REG_PRESS, TICK_W'(plan_press));
			add_cfg(REG_RELEASE, TICK_W'(plan_release));
			if (seg == 2) begin
				// block the receiver and keep offering until the input stalls
				add_pace(0, 0);
				add_ctl(ST_HOLD);
				repeat (24) add_req($urandom_range(1) ? CMD_SCAN : CMD_POP, KEY_W'($urandom),
					RAW_W'($urandom), RAW_W'($urandom));
				add_ctl(ST_DRAIN);
			end
			case (seg % 4)
			0: add_pace(0, 0);
			1: add_pace(67, 0);
			2: add_pace(0, 67);
			default: add_pace(29, 29);
			endcase
			goal = planned_reqs + RANDOM_REQS / SEGMENTS;
			while (planned_reqs < goal) begin
				pick = $urandom_range(99);
				if (pick < 40)
					press_release(RAW_W'($urandom_range(15, 1)));
				else if (pick < 60)
					repeat ($urandom_range(3, 1))
						add_req(CMD_POP, KEY_W'($urandom), RAW_W'($urandom), RAW_W'($urandom));
				else if (pick < 72)
					add_req(CMD_CONSUME, KEY_W'($urandom), RAW_W'($urandom), RAW_W'($urandom));
				else if (pick < 84)
					add_req(3'($urandom), KEY_W'($urandom), RAW_W'($urandom), RAW_W'($urandom));
				else if (pick < 87)
					add_req(CMD_INIT, KEY_W'($urandom), RAW_W'($urandom), RAW_W'($urandom));
				else if (pick < 97)
					add_req(pick < 92 ? CMD_EDGE : CMD_SCAN, KEY_W'($urandom), RAW_W'($urandom),
						scan_rok());
				else
					add_ctl(ST_DRAIN);
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk);
		while (stim_q.size() != 0 || in_valid || cfg_phase != 0 || predicted_reports.size() != 0);
		repeat (SETTLE) @(negedge clk);

		$display("checked %0d key reports over %0d tick settings (%0d register writes)",
			reports_taken, SEGMENTS, cfg_writes);
		$display("%0d presses were lost to a full event queue", drops_predicted);
		if (errors == 0) begin
			$display("tb_key_debounce_event_queue_core OK");
		end else begin
			$display("tb_key_debounce_event_queue_core NOT OK");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("tb_key_debounce_event_queue_core NOT OK");
		$finish;
	end

endmodule
